FILE: rtl/lruc_pkg.sv
package lruc_pkg;

  // default sizes of the cache model
  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_ADDR_WIDTH   = 32;

  // register and field widths
  localparam int SET_BITS_W   = 3;
  localparam int WAYS_W       = 4;
  localparam int BLOCK_BITS_W = 5;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 5;
  localparam int OP_W         = 2;
  localparam int OUTCOME_W    = 2;
  localparam int CNT_W        = 32;

  // register reset values
  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = SET_BITS_W'(4);
  localparam logic [WAYS_W-1:0]       WAYS_RST       = WAYS_W'(1);
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = BLOCK_BITS_W'(4);

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_WAYS       = 2'd1,
    CFG_BLOCK_BITS = 2'd2
  } cfg_reg_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_FETCH  = 2'd3
  } op_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } back_state_t;

endpackage

FILE: rtl/lruc_if.sv
interface lruc_in_if #(
  parameter int ADDR_WIDTH = lruc_pkg::DEF_ADDR_WIDTH
);
  logic                        valid;
  logic                        ready;
  logic [lruc_pkg::OP_W-1:0]   operation;
  logic [ADDR_WIDTH-1:0]       address;

  modport source (output valid, output operation, output address, input ready);
  modport sink   (input valid, input operation, input address, output ready);
endinterface

interface lruc_out_if;
  logic                           valid;
  logic                           ready;
  logic [lruc_pkg::OUTCOME_W-1:0] outcome;
  logic                           last_of_run;
  logic [lruc_pkg::CNT_W-1:0]     hits_total;
  logic [lruc_pkg::CNT_W-1:0]     misses_total;
  logic [lruc_pkg::CNT_W-1:0]     evictions_total;

  modport source (output valid, output outcome, output last_of_run, output hits_total,
                  output misses_total, output evictions_total, input ready);
  modport sink   (input valid, input outcome, input last_of_run, input hits_total,
                  input misses_total, input evictions_total, output ready);
endinterface

FILE: rtl/lruc_ram.sv
module lruc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lruc_queue.sv
module lruc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import lruc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]  slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  assign full     = (count == CNT_QW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/lruc_front.sv
module lruc_front #(
  parameter int MAX_SET_BITS = lruc_pkg::DEF_MAX_SET_BITS,
  parameter int ADDR_WIDTH   = lruc_pkg::DEF_ADDR_WIDTH
) (
  lruc_in_if.sink                                in_ch,
  input  logic [lruc_pkg::SET_BITS_W-1:0]        set_bits,
  input  logic [lruc_pkg::BLOCK_BITS_W-1:0]      block_bits,
  input  logic                                   clearing,
  input  logic                                   q_full,
  output logic                                   q_push,
  output logic [ADDR_WIDTH + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1):0] q_data
);
  import lruc_pkg::*;

  localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SHIFT_W   = SET_BITS_W + 1 > BLOCK_BITS_W ? SET_BITS_W + 2 : BLOCK_BITS_W + 1;

  logic [SHIFT_W-1:0]    tag_shift;
  logic [ADDR_WIDTH-1:0] tag;
  logic [ADDR_WIDTH-1:0] above_block;
  logic [SET_IDX_W-1:0]  set_mask;
  logic [SET_IDX_W-1:0]  set_idx;
  logic                  is_modify;

  assign in_ch.ready = !clearing && !q_full;
  assign q_push      = in_ch.valid && in_ch.ready && (op_t'(in_ch.operation) != OP_FETCH);
  assign is_modify   = (op_t'(in_ch.operation) == OP_MODIFY);

  always_comb begin
    tag_shift   = SHIFT_W'(set_bits) + SHIFT_W'(block_bits);
    tag         = (int'(tag_shift) >= ADDR_WIDTH) ? '0 : (in_ch.address >> tag_shift);
    above_block = (int'(block_bits) >= ADDR_WIDTH) ? '0 : (in_ch.address >> block_bits);
    for (int i = 0; i < SET_IDX_W; i++) begin
      set_mask[i] = (i < int'(set_bits));
    end
    set_idx = above_block[SET_IDX_W-1:0] & set_mask;
  end

  assign q_data = {is_modify, set_idx, tag};

endmodule

FILE: rtl/lruc_back.sv
module lruc_back #(
  parameter int MAX_SET_BITS = lruc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = lruc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH   = lruc_pkg::DEF_ADDR_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [lruc_pkg::WAYS_W-1:0]            ways,
  input  logic                                   q_empty,
  input  logic [ADDR_WIDTH + ((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1):0] q_data,
  output logic                                   q_pop,
  output logic                                   clearing,
  lruc_out_if.source                             out_ch
);
  import lruc_pkg::*;

  localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int AGE_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int META_W    = MAX_WAYS * (1 + AGE_W);
  localparam int TAGROW_W  = MAX_WAYS * ADDR_WIDTH;

  back_state_t state, state_next;

  logic [SET_IDX_W-1:0]  clr_idx;
  logic [ADDR_WIDTH-1:0] cur_tag;
  logic [SET_IDX_W-1:0]  cur_set;
  logic                  cur_modify;
  logic                  second;
  logic                  out_valid;
  outcome_t              out_outcome;
  logic                  out_last;
  logic [CNT_W-1:0]      hits;
  logic [CNT_W-1:0]      misses;
  logic [CNT_W-1:0]      evictions;

  logic                  out_free;
  logic                  rd_en;
  logic [SET_IDX_W-1:0]  rd_addr;
  logic                  meta_we;
  logic                  tag_we;
  logic [SET_IDX_W-1:0]  wr_addr;
  logic                  load_out;
  logic [META_W-1:0]     meta_rd;
  logic [META_W-1:0]     meta_wr;
  logic [META_W-1:0]     meta_new;
  logic [TAGROW_W-1:0]   tag_rd;
  logic [TAGROW_W-1:0]   tag_new;

  logic                  in_use    [MAX_WAYS];
  logic                  row_valid [MAX_WAYS];
  logic [AGE_W-1:0]      row_age   [MAX_WAYS];
  logic [AGE_W-1:0]      new_age   [MAX_WAYS];
  logic [MAX_WAYS-1:0]   hit_vec;
  logic [MAX_WAYS-1:0]   free_vec;
  logic [WAY_W-1:0]      hit_way;
  logic [WAY_W-1:0]      free_way;
  logic [WAY_W-1:0]      victim_way;
  logic [AGE_W-1:0]      victim_age;
  logic [WAY_W-1:0]      sel_way;
  logic [AGE_W-1:0]      ref_age;
  logic                  hit_found;
  logic                  free_found;
  outcome_t              outcome;

  assign out_free = !out_valid || out_ch.ready;
  assign clearing = (state == ST_CLEAR);

  lruc_ram #(.WIDTH(META_W), .DEPTH(NUM_SETS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (wr_addr),
    .wdata (meta_wr),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (meta_rd)
  );

  lruc_ram #(.WIDTH(TAGROW_W), .DEPTH(NUM_SETS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (wr_addr),
    .wdata (tag_new),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (tag_rd)
  );

  // set lookup on the row that the memory read in ST_IDLE registered
  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i]    = (WAYS_W'(i) < ways);
      row_valid[i] = meta_rd[i];
      row_age[i]   = meta_rd[MAX_WAYS + i*AGE_W +: AGE_W];
      hit_vec[i]   = in_use[i] && row_valid[i] &&
                     (tag_rd[i*ADDR_WIDTH +: ADDR_WIDTH] == cur_tag);
      free_vec[i]  = in_use[i] && !row_valid[i];
    end
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WAY_W'(i);
      end
      if (free_vec[i]) begin
        free_way = WAY_W'(i);
      end
    end
    hit_found  = |hit_vec;
    free_found = |free_vec;

    // oldest way, first on a tie
    victim_way = '0;
    victim_age = row_age[0];
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && (row_age[i] > victim_age)) begin
        victim_way = WAY_W'(i);
        victim_age = row_age[i];
      end
    end

    if (hit_found) begin
      outcome = OUT_HIT;
      sel_way = hit_way;
    end else if (free_found) begin
      outcome = OUT_FILL;
      sel_way = free_way;
    end else begin
      outcome = OUT_EVICT;
      sel_way = victim_way;
    end
    ref_age = row_age[sel_way];

    for (int i = 0; i < MAX_WAYS; i++) begin
      new_age[i] = row_age[i];
      if (in_use[i] && row_valid[i] && (WAY_W'(i) != sel_way) &&
          (!hit_found || (row_age[i] < ref_age)) &&
          (row_age[i] < AGE_W'(MAX_WAYS - 1))) begin
        new_age[i] = row_age[i] + 1'b1;
      end
    end
    new_age[sel_way] = '0;

    meta_new = meta_rd;
    meta_new[sel_way] = 1'b1;
    for (int i = 0; i < MAX_WAYS; i++) begin
      meta_new[MAX_WAYS + i*AGE_W +: AGE_W] = new_age[i];
    end
    tag_new = tag_rd;
    tag_new[sel_way*ADDR_WIDTH +: ADDR_WIDTH] = cur_tag;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == SET_IDX_W'(NUM_SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (second || !q_empty) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = second ? cur_set : q_data[ADDR_WIDTH +: SET_IDX_W];
    q_pop    = 1'b0;
    meta_we  = 1'b0;
    tag_we   = 1'b0;
    wr_addr  = cur_set;
    meta_wr  = meta_new;
    load_out = 1'b0;
    case (state)
      ST_CLEAR: begin
        meta_we = 1'b1;
        wr_addr = clr_idx;
        meta_wr = '0;
      end
      ST_IDLE: begin
        rd_en = second || !q_empty;
        q_pop = !second && !q_empty;
      end
      ST_LOOK: begin
        meta_we  = out_free;
        tag_we   = out_free;
        load_out = out_free;
      end
      default: begin
        meta_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_tag    <= q_data[ADDR_WIDTH-1:0];
      cur_set    <= q_data[ADDR_WIDTH +: SET_IDX_W];
      cur_modify <= q_data[ADDR_WIDTH + SET_IDX_W];
    end
    if (load_out) begin
      out_outcome <= outcome;
      out_last    <= !(cur_modify && !second);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      second    <= 1'b0;
      out_valid <= 1'b0;
      hits      <= '0;
      misses    <= '0;
      evictions <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        second    <= cur_modify && !second;
        if (outcome == OUT_HIT) begin
          hits <= (hits == '1) ? hits : hits + 1'b1;
        end else begin
          misses <= (misses == '1) ? misses : misses + 1'b1;
        end
        if (outcome == OUT_EVICT) begin
          evictions <= (evictions == '1) ? evictions : evictions + 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.outcome         = out_outcome;
  assign out_ch.last_of_run     = out_last;
  assign out_ch.hits_total      = hits;
  assign out_ch.misses_total    = misses;
  assign out_ch.evictions_total = evictions;

endmodule

FILE: rtl/set_assoc_lru_cache_sim.sv
// channel   dir  handshake          payload
// in_ch     in   valid / ready      operation, address
// out_ch    out  valid / ready      outcome, last_of_run, hits_total, misses_total,
//                                   evictions_total
// cfg       in   cfg_write_en       cfg_index, cfg_data
//
// in the back end a load or store first reads the set row from the tag and state memories,
// then picks the way and writes the row back once out_ch can take the result
// a modify makes two passes over the same set; a fetch is dropped at the front
// after reset a clearing pass over all 2**MAX_SET_BITS sets (64 by default) zeroes the
// valid and age bits; no item is accepted meanwhile
// a two-entry queue lets the front keep taking items while the back waits on out_ch
module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = lruc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = lruc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH   = lruc_pkg::DEF_ADDR_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  lruc_in_if.sink                          in_ch,
  lruc_out_if.source                       out_ch,
  input  logic                             cfg_write_en,
  input  logic [lruc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lruc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lruc_pkg::*;

  localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ENTRY_W   = 1 + SET_IDX_W + ADDR_WIDTH;

  // configuration registers as written
  logic [SET_BITS_W-1:0]   set_bits;
  logic [WAYS_W-1:0]       ways_in_use;
  logic [BLOCK_BITS_W-1:0] block_bits;

  // values clamped to what the storage supports
  logic [SET_BITS_W-1:0]   set_bits_eff;
  logic [WAYS_W-1:0]       ways_eff;

  // front to back queue
  logic               q_push;
  logic [ENTRY_W-1:0] q_wdata;
  logic               q_full;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_rdata;
  logic               q_empty;
  logic               clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= SET_BITS_RST;
      ways_in_use <= WAYS_RST;
      block_bits  <= BLOCK_BITS_RST;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SET_BITS:   set_bits    <= cfg_data[SET_BITS_W-1:0];
        CFG_WAYS:       ways_in_use <= cfg_data[WAYS_W-1:0];
        CFG_BLOCK_BITS: block_bits  <= cfg_data[BLOCK_BITS_W-1:0];
        default:        ; // unknown register index, write dropped
      endcase
    end
  end

  // set bits beyond the table act as the maximum; zero ways act as one, ways beyond MAX_WAYS as MAX_WAYS
  always_comb begin
    set_bits_eff = (int'(set_bits) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS) : set_bits;
    if (ways_in_use == '0) begin
      ways_eff = WAYS_W'(1);
    end else if (int'(ways_in_use) > MAX_WAYS) begin
      ways_eff = WAYS_W'(MAX_WAYS);
    end else begin
      ways_eff = ways_in_use;
    end
  end

  // front: splits the address, drops fetches, queues the rest
  lruc_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_front (
    .in_ch      (in_ch),
    .set_bits   (set_bits_eff),
    .block_bits (block_bits),
    .clearing   (clearing),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  lruc_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // back: set read-modify-write, lru update, counters and result register
  lruc_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .ways     (ways_eff),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule
